### rtl/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types, constants and helpers of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

  // Pattern store capacity in characters.
  localparam int PATTERN_LEN = 64;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int OFS_W  = 6;

  // Pattern length counter (0 .. PATTERN_LEN) and store index.
  localparam int POS_W = $clog2(PATTERN_LEN + 1);
  localparam int IDX_W = $clog2(PATTERN_LEN);
  // Stored alternative start offsets keep only the bits that are reported.
  localparam int ST_W  = (POS_W < OFS_W) ? POS_W : OFS_W;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] SEP_CHAR = 8'h7C; // '|'
  localparam logic [CHAR_W-1:0] ANY_CHAR = 8'h3F; // '?'
  localparam logic [CHAR_W-1:0] RUN_CHAR = 8'h2A; // '*'
  localparam logic [CHAR_W-1:0] UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TOKEN  = 2'd2,
    OP_END    = 2'd3
  } op_e;

  // Classified request as it travels from front to back.
  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] chr;     // case-folded character
    logic              is_sep;
    logic              is_any;
    logic              is_run;
  } cmd_t;

  // ASCII lower-case folding.
  function automatic logic [CHAR_W-1:0] fold_char(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage

### rtl/wpm_in_if.sv
// ----------------------------------------------------------------------------
// wpm_in_if
// Request channel: operation code and character with valid/ready.
// ----------------------------------------------------------------------------
interface wpm_in_if import wpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output operation, output character, input ready);
  modport sink   (input valid, input operation, input character, output ready);
endinterface

### rtl/wpm_out_if.sv
// ----------------------------------------------------------------------------
// wpm_out_if
// Result channel: match flag, alternative offset and overflow flag.
// ----------------------------------------------------------------------------
interface wpm_out_if import wpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             matched;
  logic [OFS_W-1:0] alternative_offset;
  logic             pattern_overflow;

  modport source (output valid, output matched, output alternative_offset,
                  output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input alternative_offset,
                  input pattern_overflow, output ready);
endinterface

### rtl/wpm_front.sv
// ----------------------------------------------------------------------------
// wpm_front
// Decode and classify incoming requests, fold case, push into the queue.
// ----------------------------------------------------------------------------
module wpm_front import wpm_pkg::*; (
  wpm_in_if.sink in_i,
  output cmd_t   push_cmd_o,
  output logic   push_valid_o,
  input  logic   push_ready_i
);

  logic [CHAR_W-1:0] raw;

  always_comb begin
    raw                = in_i.character;
    push_cmd_o.op      = op_e'(in_i.operation);
    push_cmd_o.chr     = fold_char(raw);
    push_cmd_o.is_sep  = (raw == SEP_CHAR);
    push_cmd_o.is_any  = (raw == ANY_CHAR);
    push_cmd_o.is_run  = (raw == RUN_CHAR);
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

### rtl/wpm_queue.sv
// ----------------------------------------------------------------------------
// wpm_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module wpm_queue import wpm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o,
  input  logic pop_i
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = slot_q[rd_ptr_q];

  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/wpm_back.sv
// ----------------------------------------------------------------------------
// wpm_back
// Pattern store, parallel position automaton and result pipeline.
// ----------------------------------------------------------------------------
module wpm_back import wpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  cmd_t      head_cmd_i,
  output logic      pop_o,
  wpm_out_if.source out_o
);

  localparam int N = PATTERN_LEN;

  // Let every active star also cover the position after it (empty run).
  // Prefix form of the ripple: run bits propagate, active bits generate.
  function automatic logic [N:0] close_runs(logic [N:0] v, logic [N-1:0] run);
    logic [N:0] g, p, g_n, p_n;
    g = v;
    p = {run, 1'b0};
    for (int d = 1; d <= N; d = d * 2) begin
      g_n = g;
      p_n = p;
      for (int i = d; i <= N; i++) begin
        g_n[i] = g[i] | (p[i] & g[i-d]);
        p_n[i] = p[i] & p[i-d];
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

  typedef struct packed {
    logic [N-1:0]    hits;      // active separator positions
    logic            end_hit;   // active at end of pattern
    logic [ST_W-1:0] start;     // start of last alternative
    logic            ovf;
  } sel_t;

  // Pattern store (payload, valid only below the length).
  logic [CHAR_W-1:0] lit_q   [N];
  logic [ST_W-1:0]   alt_st_q [N];
  logic [N-1:0]      sep_q, any_q, run_q;

  // Control state.
  logic [POS_W-1:0]  len_q;
  logic [N-1:0]      len_mask_q;
  logic [N:0]        endpos_q;
  logic [N:0]        init_q;
  logic [N:0]        active_q;
  logic              tail_q;
  logic              prev_sep_q;
  logic [ST_W-1:0]   cur_start_q;
  logic              tip_q;
  logic              ovf_q;

  logic              s1_v_q;
  sel_t              s1_q;
  logic              ov_q;
  logic              matched_q;
  logic [OFS_W-1:0]  offset_q;
  logic              povf_q;

  cmd_t              cmd;
  logic              full, do_exec, can_go, out_load, append_ok;
  logic [IDX_W-1:0]  idx;
  logic [POS_W-1:0]  len_inc;
  logic              init_l;
  logic [N:0]        cur, step, next_act;
  logic [N-1:0]      hits, lowest;
  logic [ST_W-1:0]   sel_st;

  assign cmd       = head_cmd_i;
  assign full      = (len_q == POS_W'(N));
  assign idx       = len_q[IDX_W-1:0];
  assign len_inc   = len_q + POS_W'(1);
  assign init_l    = tail_q | prev_sep_q;
  assign out_load  = s1_v_q & (~ov_q | out_o.ready);

  // Pattern changes and ends of token wait while a result still reads the start table.
  always_comb begin
    case (cmd.op)
      OP_CLEAR, OP_APPEND: can_go = ~s1_v_q | out_load;
      OP_END:              can_go = ~s1_v_q | out_load;
      OP_TOKEN:            can_go = 1'b1;
      default:             can_go = 1'b1;
    endcase
  end

  assign do_exec   = head_valid_i & can_go;
  assign pop_o     = do_exec;
  assign append_ok = do_exec & (cmd.op == OP_APPEND) & ~full;

  // One character step over all positions.
  always_comb begin
    cur  = tip_q ? active_q : init_q;
    step = '0;
    for (int p = 0; p < N; p++) begin
      if (cur[p] && len_mask_q[p]) begin
        if (run_q[p]) begin
          step[p] = 1'b1;
        end else if (!sep_q[p] && (any_q[p] || lit_q[p] == cmd.chr)) begin
          step[p+1] = 1'b1;
        end
      end
    end
    next_act = close_runs(step, run_q & len_mask_q);
    hits     = cur[N-1:0] & sep_q & len_mask_q;
  end

  // Pick the lowest active separator and its alternative start.
  always_comb begin
    lowest = s1_q.hits & (~s1_q.hits + N'(1));
    sel_st = '0;
    for (int p = 0; p < N; p++) begin
      if (lowest[p]) begin
        sel_st = sel_st | alt_st_q[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      len_mask_q  <= '0;
      endpos_q    <= (N+1)'(1);
      init_q      <= (N+1)'(1);
      active_q    <= '0;
      tail_q      <= 1'b1;
      prev_sep_q  <= 1'b0;
      cur_start_q <= '0;
      tip_q       <= 1'b0;
      ovf_q       <= 1'b0;
      s1_v_q      <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      if (do_exec) begin
        case (cmd.op)
          OP_CLEAR: begin
            len_q       <= '0;
            len_mask_q  <= '0;
            endpos_q    <= (N+1)'(1);
            init_q      <= (N+1)'(1);
            tail_q      <= 1'b1;
            prev_sep_q  <= 1'b0;
            cur_start_q <= '0;
            ovf_q       <= 1'b0;
            active_q    <= '0;
            tip_q       <= 1'b0;
          end
          OP_APPEND: begin
            active_q <= '0;
            tip_q    <= 1'b0;
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              len_q                 <= len_inc;
              len_mask_q[idx]       <= 1'b1;
              endpos_q              <= {endpos_q[N-1:0], 1'b0};
              init_q[len_q]         <= init_l;
              init_q[len_inc]       <= init_l & cmd.is_run;
              tail_q                <= init_l & cmd.is_run;
              prev_sep_q            <= cmd.is_sep;
              if (cmd.is_sep) begin
                cur_start_q <= len_inc[ST_W-1:0];
              end
            end
          end
          OP_TOKEN: begin
            active_q <= next_act;
            tip_q    <= 1'b1;
          end
          OP_END: begin
            active_q <= '0;
            tip_q    <= 1'b0;
          end
          default: begin
            tip_q <= tip_q;
          end
        endcase
      end

      if (do_exec && cmd.op == OP_END) begin
        s1_v_q <= 1'b1;
      end else if (out_load) begin
        s1_v_q <= 1'b0;
      end

      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (append_ok) begin
      lit_q[idx]    <= cmd.chr;
      alt_st_q[idx] <= cur_start_q;
      sep_q[idx]    <= cmd.is_sep;
      any_q[idx]    <= cmd.is_any;
      run_q[idx]    <= cmd.is_run;
    end
    if (do_exec && cmd.op == OP_END) begin
      s1_q.hits    <= hits;
      s1_q.end_hit <= |(cur & endpos_q);
      s1_q.start   <= cur_start_q;
      s1_q.ovf     <= ovf_q;
    end
    if (out_load) begin
      matched_q <= (|s1_q.hits) | s1_q.end_hit;
      povf_q    <= s1_q.ovf;
      if (|s1_q.hits) begin
        offset_q <= OFS_W'(sel_st);
      end else if (s1_q.end_hit) begin
        offset_q <= OFS_W'(s1_q.start);
      end else begin
        offset_q <= '0;
      end
    end
  end

  assign out_o.valid              = ov_q;
  assign out_o.matched            = matched_q;
  assign out_o.alternative_offset = offset_q;
  assign out_o.pattern_overflow   = povf_q;

endmodule

### rtl/wildcard_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_top
// Case-insensitive glob matcher with '|' alternatives, '?' and '*'.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  in_i     in   valid/ready   operation[1:0], character[7:0]
//  out_o    out  valid/ready   matched, alternative_offset[5:0], pattern_overflow
//
//  One request per cycle while the queue has room; an end-of-token result passes
//  from its request through the queue, the select stage and the output register.
//  A clear or append right behind an end of token waits until that result
//  has left the select stage, which reads the alternative start table.
//  Reset clears all control state at once; no clearing pass follows.
//  A stalled result holds in the output register while requests keep flowing
//  into the queue until it fills.
//
module wildcard_pattern_matcher_top import wpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpm_in_if.sink    in_i,
  wpm_out_if.source out_o
);

  cmd_t push_cmd;
  logic push_valid;
  logic push_ready;
  cmd_t head_cmd;
  logic head_valid;
  logic pop;

  // Front: decode, fold case, classify the character.
  wpm_front u_front (
    .in_i         (in_i),
    .push_cmd_o   (push_cmd),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  // Queue: hold classified requests so each side can stall on its own.
  wpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  // Back: pattern store, position automaton, result pipeline.
  wpm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

### tb/wpm_match_checker.sv
// ----------------------------------------------------------------------------
// wpm_match_checker
// Watches the request and result channels of the wildcard pattern matcher,
// tracks pattern and match state on every accepted request and compares each
// accepted result with the oldest predicted one.
// ----------------------------------------------------------------------------
module wpm_match_checker import wpm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  wpm_in_if    req_i,
  wpm_out_if   res_i,
  output int   fail_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    logic             matched;
    logic [OFS_W-1:0] offset;
    logic             overflow;
  } match_res_t;

  logic [CHAR_W-1:0]  pat_mem [PATTERN_LEN];
  int                 pat_len;
  logic [PATTERN_LEN:0] live;
  logic               tok_open;
  logic               ovf_flag;
  match_res_t         verdict_q [$];
  int                 n_fail;

  function automatic logic [CHAR_W-1:0] to_lower(logic [CHAR_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic bit alt_begins(int p);
    if (p == 0) begin
      return 1'b1;
    end
    return (p < pat_len) && (pat_mem[p-1] == SEP_CHAR);
  endfunction

  // Let every live star also step past itself (empty run).
  function automatic logic [PATTERN_LEN:0] skip_runs(logic [PATTERN_LEN:0] v);
    logic [PATTERN_LEN:0] r;
    r = v;
    for (int p = 0; p < pat_len; p++) begin
      if (r[p] && pat_mem[p] == RUN_CHAR) begin
        r[p+1] = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic open_token();
    live = '0;
    for (int p = 0; p <= pat_len; p++) begin
      if (alt_begins(p)) begin
        live[p] = 1'b1;
      end
    end
    live     = skip_runs(live);
    tok_open = 1'b1;
  endtask

  task automatic advance_char(logic [CHAR_W-1:0] c);
    logic [PATTERN_LEN:0] nxt;
    logic [CHAR_W-1:0]    pc;
    nxt = '0;
    for (int p = 0; p < pat_len; p++) begin
      pc = pat_mem[p];
      if (live[p] && pc != SEP_CHAR) begin
        if (pc == RUN_CHAR) begin
          nxt[p] = 1'b1;
        end else if (pc == ANY_CHAR || to_lower(pc) == to_lower(c)) begin
          nxt[p+1] = 1'b1;
        end
      end
    end
    live = skip_runs(nxt);
  endtask

  task automatic close_token();
    match_res_t r;
    int         base;
    r    = '0;
    base = 0;
    for (int p = 0; p <= pat_len; p++) begin
      if (alt_begins(p)) begin
        base = p;
      end
      if (!r.matched && live[p] && ((p == pat_len) || (pat_mem[p] == SEP_CHAR))) begin
        r.matched = 1'b1;
        r.offset  = base[OFS_W-1:0];
      end
    end
    r.overflow = ovf_flag;
    verdict_q.push_back(r);
    tok_open = 1'b0;
    live     = '0;
  endtask

  task automatic apply_request(op_e op, logic [CHAR_W-1:0] c);
    case (op)
      OP_CLEAR, OP_APPEND: begin
        tok_open = 1'b0;
        live     = '0;
        if (op == OP_CLEAR) begin
          pat_len  = 0;
          ovf_flag = 1'b0;
        end else if (pat_len < PATTERN_LEN) begin
          pat_mem[pat_len] = c;
          pat_len++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      OP_TOKEN: begin
        if (!tok_open) begin
          open_token();
        end
        advance_char(c);
      end
      default: begin
        if (!tok_open) begin
          open_token();
        end
        close_token();
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    match_res_t want;
    match_res_t got;
    if (!rst_ni) begin
      pat_len  = 0;
      live     = '0;
      tok_open = 1'b0;
      ovf_flag = 1'b0;
      n_fail   = 0;
      verdict_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.matched, res_i.alternative_offset, res_i.pattern_overflow};
        if (verdict_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("ERROR: result with none pending: matched=%0d offset=%0d overflow=%0d",
                     got.matched, got.offset, got.overflow);
          end
        end else begin
          want = verdict_q.pop_front();
          if (got.matched !== want.matched || got.offset !== want.offset ||
              got.overflow !== want.overflow) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("ERROR: result mismatch: expected matched=%0d offset=%0d overflow=%0d",
                       want.matched, want.offset, want.overflow);
              $display("       got matched=%0d offset=%0d overflow=%0d",
                       got.matched, got.offset, got.overflow);
            end
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        apply_request(op_e'(req_i.operation), req_i.character);
      end
      fail_cnt_o <= n_fail;
      pending_o  <= verdict_q.size();
    end
  end

endmodule

### tb/tb_wildcard_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// tb_wildcard_pattern_matcher_top
// Drives pattern loads, tokens and ends of token into the matcher, with
// random gaps on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_wildcard_pattern_matcher_top;
  import wpm_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic quiet;        // suppress idling on both sides
  int   n_sent;
  int   fail_cnt;
  int   pending;

  // Mirror of the stored pattern, used only to build tokens that match.
  logic [CHAR_W-1:0] pat_copy [$];
  logic [CHAR_W-1:0] tok_buf  [$];

  wpm_in_if  req_if ();
  wpm_out_if res_if ();

  wildcard_pattern_matcher_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  wpm_match_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_i      (res_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Stall the result side at random, with a chance of 9 in 100, except in the quiet stretch.
  always @(posedge clk_i) begin
    res_if.ready <= quiet || ($urandom_range(99) >= 9);
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Issue one request and hold it until the block takes it. Keep valid high
  // afterwards so back-to-back requests need no second assignment per step.
  task automatic send_req(input op_e op, input logic [CHAR_W-1:0] ch);
    if (!quiet && $urandom_range(99) < 9) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 30);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.character <= ch;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    n_sent++;
    // Track what the store will hold; characters past capacity get dropped.
    if (op == OP_CLEAR) begin
      pat_copy.delete();
    end else if (op == OP_APPEND && pat_copy.size() < PATTERN_LEN) begin
      pat_copy.push_back(ch);
    end
  endtask

  // Drop valid and hold off until every outstanding result has arrived.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // A letter from a small alphabet, either case, so tokens hit often.
  function automatic logic [CHAR_W-1:0] pick_letter();
    logic [CHAR_W-1:0] c;
    c = 8'h61 + 8'($urandom_range(0, 3));
    if ($urandom_range(1)) begin
      c = c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_pattern_char();
    int r;
    r = $urandom_range(99);
    if (r < 40) return pick_letter();
    if (r < 52) return ANY_CHAR;
    if (r < 66) return RUN_CHAR;
    if (r < 80) return SEP_CHAR;
    return 8'($urandom_range(255));
  endfunction

  // Fill tok_buf with a token built from one random alternative of the
  // current pattern: expand stars, fill wildcards, flip letter case.
  task automatic derive_token();
    int starts [$];
    int p;
    logic [CHAR_W-1:0] c;
    starts.push_back(0);
    for (int i = 0; i < pat_copy.size(); i++) begin
      if (pat_copy[i] == SEP_CHAR && i + 1 < pat_copy.size()) begin
        starts.push_back(i + 1);
      end
    end
    tok_buf.delete();
    p = starts[$urandom_range(starts.size() - 1)];
    while (p < pat_copy.size() && pat_copy[p] != SEP_CHAR) begin
      c = pat_copy[p];
      if (c == RUN_CHAR) begin
        repeat ($urandom_range(0, 2)) tok_buf.push_back(pick_letter());
      end else if (c == ANY_CHAR) begin
        tok_buf.push_back(8'($urandom_range(255)));
      end else if (((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A) && $urandom_range(1)) begin
        tok_buf.push_back(c ^ 8'h20);
      end else begin
        tok_buf.push_back(c);
      end
      p++;
    end
  endtask

  // One well-formed session: optional clear, pattern load, several tokens.
  task automatic run_session(input bit long_pat);
    int len;
    if ($urandom_range(99) < 90) begin
      send_req(OP_CLEAR, 8'($urandom_range(255)));
    end
    // Long loads come near the store's capacity and may push past it, raising the overflow flag.
    len = long_pat ? $urandom_range(60, 72) : $urandom_range(0, 10);
    repeat (len) send_req(OP_APPEND, pick_pattern_char());
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(99) < 70) begin
        derive_token();
        // Occasionally corrupt one character to force a near miss.
        if (tok_buf.size() > 0 && $urandom_range(99) < 15) begin
          tok_buf[$urandom_range(tok_buf.size() - 1)] = 8'($urandom_range(255));
        end
      end else begin
        tok_buf.delete();
        repeat ($urandom_range(0, 6)) begin
          tok_buf.push_back($urandom_range(1) ? pick_letter() : 8'($urandom_range(255)));
        end
      end
      foreach (tok_buf[i]) send_req(OP_TOKEN, tok_buf[i]);
      send_req(OP_END, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int n_sess;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    quiet            = 1'b0;
    n_sent           = 0;
    n_sess           = 0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_CLEAR;
    req_if.character = '0;
    res_if.ready     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty pattern: only the empty token matches, at offset 0.
    send_req(OP_END, 8'h00);
    send_req(OP_TOKEN, "a");
    send_req(OP_END, 8'h00);
    // "A?|*": case folding, single wildcard, star alternative at offset 3.
    send_req(OP_APPEND, "A");
    send_req(OP_APPEND, ANY_CHAR);
    send_req(OP_APPEND, SEP_CHAR);
    send_req(OP_APPEND, RUN_CHAR);
    send_req(OP_TOKEN, "a");
    send_req(OP_TOKEN, "Z");
    send_req(OP_END, 8'h00);
    send_req(OP_TOKEN, 8'hFF);
    send_req(OP_END, 8'hFF);
    send_req(OP_END, 8'h00);
    // Clear in the middle of a token aborts it; no result follows.
    send_req(OP_TOKEN, "x");
    send_req(OP_CLEAR, 8'hFF);
    // Star run followed by a trailing separator: empty token matches.
    send_req(OP_APPEND, RUN_CHAR);
    send_req(OP_APPEND, RUN_CHAR);
    send_req(OP_APPEND, SEP_CHAR);
    send_req(OP_END, 8'h00);
    // Zero byte as an ordinary literal.
    send_req(OP_CLEAR, 8'h00);
    send_req(OP_APPEND, 8'h00);
    send_req(OP_TOKEN, 8'h00);
    send_req(OP_END, 8'h00);
    drain();

    // Random sessions; a quiet stretch in the middle with no idling at all.
    while (n_sent < 1000) begin
      quiet = (n_sent >= 400 && n_sent < 600);
      if ($urandom_range(99) < 15) begin
        // Noise: arbitrary operations, aborted tokens, bare ends of token.
        repeat ($urandom_range(1, 6)) begin
          send_req(op_e'(2'($urandom_range(3))), 8'($urandom_range(255)));
        end
      end else begin
        run_session(n_sess % 12 == 5);
      end
      n_sess++;
      if (n_sess % 20 == 0) begin
        drain();
      end
    end
    quiet = 1'b0;

    // Wait out every pending result plus the pipeline depth, then decide.
    drain();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
